// File: rtl/core/infix_to_postfix_converter_defines.svh
`ifndef INFIX_TO_POSTFIX_CONVERTER_DEFINES_SVH
`define INFIX_TO_POSTFIX_CONVERTER_DEFINES_SVH

// Same-cycle check, sampled on clk and disabled while rst is high.
`define ITP_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle check, sampled on clk and disabled while rst is high.
`define ITP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/itp_pkg.sv
package itp_pkg;

  typedef logic [2:0]  cmd_t;
  typedef logic [2:0]  op_t;
  typedef logic [15:0] ref_t;
  typedef logic [1:0]  kind_t;
  typedef logic [1:0]  err_t;
  typedef logic [1:0]  prio_t;

  localparam cmd_t CMD_OPERAND = 3'd0;
  localparam cmd_t CMD_OPERATOR = 3'd1;
  localparam cmd_t CMD_OPEN = 3'd2;
  localparam cmd_t CMD_CLOSE = 3'd3;
  localparam cmd_t CMD_END = 3'd4;

  localparam op_t OP_ADD = 3'd0;
  localparam op_t OP_SUB = 3'd1;
  localparam op_t OP_MUL = 3'd2;
  localparam op_t OP_DIV = 3'd3;
  localparam op_t OP_SQRT = 3'd4;
  localparam op_t OP_SIN = 3'd5;
  localparam op_t OP_COS = 3'd6;
  // Stack code of an open parenthesis; also an invalid operator code.
  localparam op_t PAREN_MARK = 3'd7;

  localparam kind_t KIND_OPERAND = 2'd0;
  localparam kind_t KIND_OPERATOR = 2'd1;
  localparam kind_t KIND_NONE = 2'd2;

  localparam err_t ERR_NONE = 2'd0;
  localparam err_t ERR_OVERFLOW = 2'd1;
  localparam err_t ERR_UNMATCHED_CLOSE = 2'd2;
  localparam err_t ERR_UNMATCHED_OPEN = 2'd3;

  function automatic prio_t prio_of(op_t op);
    if (op <= OP_SUB) begin
      return 2'd1;
    end else if (op <= OP_DIV) begin
      return 2'd2;
    end
    return 2'd3;
  endfunction

endpackage

// File: rtl/core/itp_token_if.sv
interface itp_token_if import itp_pkg::*; ();
  logic valid;
  logic ready;
  cmd_t command;
  op_t  op_code;
  ref_t operand_ref;

  modport source(output valid, command, op_code, operand_ref, input ready);
  modport sink(input valid, command, op_code, operand_ref, output ready);
endinterface

// File: rtl/core/itp_result_if.sv
interface itp_result_if import itp_pkg::*; ();
  logic  valid;
  logic  ready;
  kind_t out_kind;
  op_t   out_op;
  ref_t  out_operand;
  logic  last;
  err_t  error;

  modport source(output valid, out_kind, out_op, out_operand, last, error, input ready);
  modport sink(input valid, out_kind, out_op, out_operand, last, error, output ready);
endinterface

// File: rtl/core/infix_to_postfix_converter.sv
// Channel  Dir  Fields
// tok      in   command, op_code, operand_ref
// res      out  out_kind, out_op, out_operand, last, error
//
// An operand is emitted straight from idle; a push (operator, function, open paren)
// passes through the push state. Each stack entry examined is read from the stack RAM
// and then evaluated; an operator also examines the entry that stops its pops.
// An end marker or a close paren with no open paren also passes through a final state.
// Reset empties the stack pointer; the stack RAM itself is not cleared.
// Results sit in an output register; the sequencer holds while it is full and unread.
`include "infix_to_postfix_converter_defines.svh"

module infix_to_postfix_converter import itp_pkg::*; #(
  parameter int STACK_DEPTH = 32
) (
  input logic         clk,
  input logic         rst,
  itp_token_if.sink   tok,
  itp_result_if.source res
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {S_IDLE, S_PUSH, S_READ, S_EVAL, S_FINAL} state_t;
  typedef enum logic [1:0] {M_OPR, M_CLOSE, M_END} mode_t;

  state_t         state;
  mode_t          mode;
  logic [SPW-1:0] sp;
  op_t            push_val;
  prio_t          cur_prio;
  logic           pend_valid;
  op_t            pend_op;
  logic           open_left;

  logic  out_valid;
  kind_t out_kind;
  op_t   out_op;
  ref_t  out_operand;
  logic  out_last;
  err_t  out_error;

  logic           can_emit;
  logic           accept;
  logic           stack_full;
  logic [SPW-1:0] sp_dec;
  op_t            top_val;
  logic           top_stops;
  logic           wr_en;

  logic  emit_en;
  kind_t emit_kind;
  op_t   emit_op;
  ref_t  emit_operand;
  logic  emit_last;
  err_t  emit_err;

  assign can_emit = !out_valid || res.ready;
  assign tok.ready = (state == S_IDLE) && can_emit;
  assign accept = tok.valid && tok.ready;
  assign stack_full = (sp == SPW'(STACK_DEPTH));
  assign sp_dec = sp - SPW'(1);
  assign top_stops = (top_val == PAREN_MARK) || (prio_of(top_val) < cur_prio);
  assign wr_en = (state == S_PUSH) && can_emit && !stack_full;

  assign res.valid = out_valid;
  assign res.out_kind = out_kind;
  assign res.out_op = out_op;
  assign res.out_operand = out_operand;
  assign res.last = out_last;
  assign res.error = out_error;

  itp_stack_ram #(
    .DEPTH(STACK_DEPTH),
    .AW(AW)
  ) u_stack (
    .clk(clk),
    .wr_en(wr_en),
    .wr_addr(sp[AW-1:0]),
    .wr_data(push_val),
    .rd_en(state == S_READ),
    .rd_addr(sp_dec[AW-1:0]),
    .rd_data(top_val)
  );

  always_comb begin
    emit_en = 1'b0;
    emit_kind = KIND_NONE;
    emit_op = OP_ADD;
    emit_operand = '0;
    emit_last = 1'b0;
    emit_err = ERR_NONE;
    unique case (state)
      S_IDLE: begin
        if (accept && tok.command == CMD_OPERAND) begin
          emit_en = 1'b1;
          emit_kind = KIND_OPERAND;
          emit_operand = tok.operand_ref;
        end
      end
      S_PUSH: begin
        if (can_emit && stack_full) begin
          emit_en = 1'b1;
          emit_err = ERR_OVERFLOW;
        end
      end
      S_EVAL: begin
        if (can_emit) begin
          if (mode == M_OPR) begin
            emit_en = !top_stops;
            emit_kind = KIND_OPERATOR;
            emit_op = top_val;
          end else begin
            // Flags belong on the final result, so a popped operator waits one step.
            emit_en = pend_valid && (top_val != PAREN_MARK || mode == M_CLOSE);
            emit_kind = KIND_OPERATOR;
            emit_op = pend_op;
          end
        end
      end
      S_FINAL: begin
        if (can_emit) begin
          emit_en = 1'b1;
          emit_kind = pend_valid ? KIND_OPERATOR : KIND_NONE;
          emit_op = pend_valid ? pend_op : OP_ADD;
          emit_last = (mode == M_END);
          if (mode == M_CLOSE) begin
            emit_err = ERR_UNMATCHED_CLOSE;
          end else if (open_left) begin
            emit_err = ERR_UNMATCHED_OPEN;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mode <= M_OPR;
      sp <= '0;
      pend_valid <= 1'b0;
      open_left <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (emit_en) begin
        out_valid <= 1'b1;
        out_kind <= emit_kind;
        out_op <= emit_op;
        out_operand <= emit_operand;
        out_last <= emit_last;
        out_error <= emit_err;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            pend_valid <= 1'b0;
            open_left <= 1'b0;
            unique case (tok.command)
              CMD_OPERATOR: begin
                if (tok.op_code != PAREN_MARK) begin
                  push_val <= tok.op_code;
                  cur_prio <= prio_of(tok.op_code);
                  mode <= M_OPR;
                  // Functions are prefix operators and pop nothing.
                  state <= (tok.op_code <= OP_DIV && sp != '0) ? S_READ : S_PUSH;
                end
              end
              CMD_OPEN: begin
                push_val <= PAREN_MARK;
                state <= S_PUSH;
              end
              CMD_CLOSE: begin
                mode <= M_CLOSE;
                state <= (sp == '0) ? S_FINAL : S_READ;
              end
              CMD_END: begin
                mode <= M_END;
                state <= (sp == '0) ? S_FINAL : S_READ;
              end
              default: ;
            endcase
          end
        end
        S_PUSH: begin
          if (can_emit) begin
            if (!stack_full) begin
              sp <= sp + SPW'(1);
            end
            state <= S_IDLE;
          end
        end
        S_READ: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          if (can_emit) begin
            if (mode == M_OPR) begin
              if (top_stops) begin
                state <= S_PUSH;
              end else begin
                sp <= sp_dec;
                state <= (sp_dec == '0) ? S_PUSH : S_READ;
              end
            end else begin
              sp <= sp_dec;
              if (top_val == PAREN_MARK) begin
                if (mode == M_CLOSE) begin
                  pend_valid <= 1'b0;
                  state <= S_IDLE;
                end else begin
                  open_left <= 1'b1;
                  state <= (sp_dec == '0) ? S_FINAL : S_READ;
                end
              end else begin
                pend_valid <= 1'b1;
                pend_op <= top_val;
                state <= (sp_dec == '0) ? S_FINAL : S_READ;
              end
            end
          end
        end
        S_FINAL: begin
          if (can_emit) begin
            pend_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ITP_ASSERT_IMPLIES(a_sp_bound, 1'b1, sp <= SPW'(STACK_DEPTH), "stack pointer past depth")
  `ITP_ASSERT_IMPLIES(a_idle_no_pend, state == S_IDLE, !pend_valid, "held pop left in idle")
  `ITP_ASSERT_IMPLIES(a_last_kind, out_valid && out_last, out_kind != KIND_OPERAND,
                      "last flag on an operand")
  `ITP_ASSERT_NEXT(a_sp_drop, state != S_EVAL, sp >= $past(sp), "stack popped outside eval")

endmodule

// File: rtl/core/itp_stack_ram.sv
module itp_stack_ram import itp_pkg::*; #(
  parameter int DEPTH = 32,
  parameter int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  op_t           wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output op_t           rd_data
);

  op_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import itp_pkg::*;

  localparam int STACK_DEPTH = 32;
  localparam int ITEM_TARGET = 340;
  localparam int TAIL_CYCLES = 100;
  localparam int CYCLE_LIMIT = 500000;

  typedef struct {
    cmd_t cmd;
    op_t  opc;
    ref_t operand_id;
    bit   drain;
  } token_t;

  typedef struct {
    kind_t kind;
    op_t   op;
    ref_t  operand;
    logic  last;
    err_t  err;
  } postfix_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  itp_token_if  tok_if ();
  itp_result_if res_if ();

  infix_to_postfix_converter #(.STACK_DEPTH(STACK_DEPTH)) uut (
    .clk(clk),
    .rst(rst),
    .tok(tok_if),
    .res(res_if)
  );

  token_t   token_q[$];
  postfix_t postfix_q[$];

  // Shadow of the operator stack
  op_t op_mem[STACK_DEPTH];
  int  stack_top = 0;

  int  items_planned = 0;
  int  items_sent = 0;
  int  phase_len = 0;
  int  send_idle = 0;
  int  recv_idle = 0;
  int  mismatches = 0;
  int  cycles = 0;
  bit  tok_busy = 1'b0;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int rank(op_t op);
    case (op)
      OP_ADD, OP_SUB: return 1;
      OP_MUL, OP_DIV: return 2;
      default: return 3;
    endcase
  endfunction

  // Work out the postfix items that one infix token releases.
  function automatic void convert_token(token_t t);
    postfix_t batch[$];
    op_t      top;
    bit       found;
    bit       open_left;
    found = 1'b0;
    open_left = 1'b0;
    case (t.cmd)
      CMD_OPERAND: begin
        batch.insert(batch.size(), '{KIND_OPERAND, '0, t.operand_id, 1'b0, ERR_NONE});
      end
      CMD_OPERATOR, CMD_OPEN: begin
        if (t.cmd == CMD_OPERATOR && t.opc == PAREN_MARK) return;
        if (t.cmd == CMD_OPERATOR && t.opc <= OP_DIV) begin
          while (stack_top > 0) begin
            top = op_mem[stack_top - 1];
            if (top == PAREN_MARK || rank(top) < rank(t.opc)) break;
            stack_top--;
            batch.insert(batch.size(), '{KIND_OPERATOR, top, '0, 1'b0, ERR_NONE});
          end
        end
        if (stack_top >= STACK_DEPTH) begin
          batch.insert(batch.size(), '{KIND_NONE, '0, '0, 1'b0, ERR_OVERFLOW});
        end else begin
          op_mem[stack_top] = (t.cmd == CMD_OPEN) ? PAREN_MARK : t.opc;
          stack_top++;
        end
      end
      CMD_CLOSE: begin
        while (stack_top > 0 && !found) begin
          stack_top--;
          top = op_mem[stack_top];
          if (top == PAREN_MARK) begin
            found = 1'b1;
          end else begin
            batch.insert(batch.size(), '{KIND_OPERATOR, top, '0, 1'b0, ERR_NONE});
          end
        end
        if (!found) begin
          if (batch.size() > 0) begin
            batch[batch.size() - 1].err = ERR_UNMATCHED_CLOSE;
          end else begin
            batch.insert(batch.size(), '{KIND_NONE, '0, '0, 1'b0, ERR_UNMATCHED_CLOSE});
          end
        end
      end
      CMD_END: begin
        while (stack_top > 0) begin
          stack_top--;
          top = op_mem[stack_top];
          if (top == PAREN_MARK) begin
            open_left = 1'b1;
          end else begin
            batch.insert(batch.size(), '{KIND_OPERATOR, top, '0, 1'b0, ERR_NONE});
          end
        end
        if (batch.size() == 0) begin
          batch.insert(batch.size(), '{KIND_NONE, '0, '0, 1'b0, ERR_NONE});
        end
        batch[batch.size() - 1].last = 1'b1;
        if (open_left) begin
          batch[batch.size() - 1].err = ERR_UNMATCHED_OPEN;
        end
      end
      default: ;
    endcase
    foreach (batch[i]) postfix_q.insert(postfix_q.size(), batch[i]);
  endfunction

  function automatic void add_token(cmd_t c, op_t o, ref_t r, bit d = 1'b0);
    token_q.insert(token_q.size(), '{c, o, r, d});
    items_planned++;
  endfunction

  function automatic void add_operand();
    add_token(CMD_OPERAND, op_t'($urandom_range(7)), ref_t'($urandom_range(65535)));
  endfunction

  function automatic void gen_term(int depth);
    int pick;
    pick = $urandom_range(9);
    if (pick < 5 || depth >= 4) begin
      add_operand();
    end else if (pick < 8) begin
      add_token(CMD_OPEN, '0, '0);
      gen_expr(depth + 1);
      add_token(CMD_CLOSE, '0, '0);
    end else begin
      // prefix function applied to the following term
      add_token(CMD_OPERATOR, op_t'($urandom_range(OP_COS, OP_SQRT)), '0);
      gen_term(depth + 1);
    end
  endfunction

  function automatic void gen_expr(int depth);
    gen_term(depth);
    repeat ($urandom_range(3)) begin
      add_token(CMD_OPERATOR, op_t'($urandom_range(OP_DIV, OP_ADD)), '0);
      gen_term(depth);
    end
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Stimulus
  initial begin
    int pick;
    int nest;
    tok_if.valid = 1'b0;
    tok_if.command = CMD_OPERAND;
    tok_if.op_code = OP_ADD;
    tok_if.operand_ref = '0;
    res_if.ready = 1'b0;

    add_token(CMD_END, OP_ADD, '0);
    add_token(CMD_CLOSE, OP_ADD, '0);
    add_token(CMD_OPERAND, OP_ADD, 16'hFFFF);
    add_token(CMD_OPERATOR, OP_ADD, '0);
    add_token(CMD_OPEN, OP_ADD, '0);
    add_token(CMD_OPERAND, OP_ADD, 16'h0000);
    add_token(CMD_OPERATOR, OP_MUL, '0);
    add_token(CMD_OPERATOR, OP_SQRT, '0);
    add_token(CMD_OPERATOR, OP_SIN, '0);
    add_token(CMD_OPERATOR, OP_COS, '0);
    add_token(CMD_OPERAND, OP_ADD, 16'h5A5A);
    add_token(CMD_CLOSE, OP_ADD, '0);
    add_token(CMD_OPERATOR, OP_SUB, '0, 1'b1);
    add_token(CMD_OPERATOR, OP_DIV, '0);
    add_token(CMD_OPERATOR, PAREN_MARK, 16'hFFFF);
    add_token(cmd_t'(5), PAREN_MARK, 16'hA5A5);
    add_token(cmd_t'(6), OP_COS, 16'h0001);
    add_token(cmd_t'(7), PAREN_MARK, 16'hFFFF);
    add_token(CMD_OPERAND, OP_ADD, 16'h1234);
    add_token(CMD_CLOSE, OP_ADD, '0);
    add_token(CMD_OPEN, OP_ADD, '0);
    add_token(CMD_OPEN, OP_ADD, '0);
    add_token(CMD_OPERATOR, OP_ADD, '0);
    add_token(CMD_END, OP_ADD, '0);
    add_token(CMD_OPEN, OP_ADD, '0);
    add_token(CMD_END, OP_ADD, '0);

    while (items_planned < ITEM_TARGET) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        // well-formed expression, sometimes with a leading drain operand or a stray paren
        if ($urandom_range(29) == 0) begin
          add_token(CMD_OPERAND, '0, ref_t'($urandom_range(65535)), 1'b1);
        end
        gen_expr(0);
        if ($urandom_range(7) == 0) begin
          add_token($urandom_range(1) ? CMD_CLOSE : CMD_OPEN, '0, '0);
        end
        add_token(CMD_END, '0, '0);
      end else if (pick < 90) begin
        // deep nesting to fill the stack and at times overflow it
        nest = $urandom_range(40, 28);
        repeat (nest) begin
          if ($urandom_range(1)) add_token(CMD_OPEN, '0, '0);
          else add_token(CMD_OPERATOR, op_t'($urandom_range(OP_COS, OP_SQRT)), '0);
        end
        add_operand();
        repeat ($urandom_range(4)) begin
          add_token(CMD_OPERATOR, op_t'($urandom_range(OP_DIV, OP_ADD)), '0);
          add_operand();
        end
        repeat ($urandom_range(6)) add_token(CMD_CLOSE, '0, '0);
        add_token(CMD_END, '0, '0);
      end else begin
        repeat ($urandom_range(8, 1)) begin
          add_token(cmd_t'($urandom_range(7)), op_t'($urandom_range(7)),
                    ref_t'($urandom_range(65535)));
        end
      end
    end
    phase_len = token_q.size() / 3;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (token_q.size() > 0 || tok_busy || postfix_q.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Driver: present items and ready at the falling edge
  always @(negedge clk) begin
    if (!rst) begin
      if (items_sent < phase_len) begin
        send_idle = 25;
        recv_idle = 56;
      end else if (items_sent < 2 * phase_len) begin
        send_idle = 56;
        recv_idle = 25;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      res_if.ready <= ($urandom_range(99) >= recv_idle);
      if (!tok_busy) begin
        // a drain item holds until every pending result has come out
        if (token_q.size() > 0 && !(token_q[0].drain && postfix_q.size() > 0) &&
            $urandom_range(99) >= send_idle) begin
          tok_if.valid <= 1'b1;
          tok_if.command <= token_q[0].cmd;
          tok_if.op_code <= token_q[0].opc;
          tok_if.operand_ref <= token_q[0].operand_id;
          tok_busy = 1'b1;
        end else begin
          tok_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: predict on each accepted token, check each accepted result
  always @(posedge clk) begin : monitor_blk
    postfix_t want;
    if (!rst) begin
      if (tok_if.valid && tok_if.ready) begin
        convert_token(token_q.pop_front());
        tok_busy = 1'b0;
        items_sent++;
      end
      if (res_if.valid && res_if.ready) begin
        if (postfix_q.size() == 0) begin
          $error("unexpected result: kind %0d op %0d operand %0d",
                 res_if.out_kind, res_if.out_op, res_if.out_operand);
          mismatches++;
        end else begin
          want = postfix_q.pop_front();
          check_field("out_kind", want.kind, res_if.out_kind);
          check_field("out_op", want.op, res_if.out_op);
          check_field("out_operand", want.operand, res_if.out_operand);
          check_field("last", want.last, res_if.last);
          check_field("error", want.err, res_if.error);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

endmodule
